// ----- sv/rcpwd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcpwd_pkg
// Shared widths, register indexes, reset values and the command and status
// words that pass between the pulse-width decoder controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpwd_pkg;

	localparam int STAMP_BITS_DEF = 16;
	localparam int CHANNELS_DEF   = 3;

	localparam int CHAN_W      = 2;
	localparam int STAMP_W     = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int PULSE_W     = 12;
	localparam int TILT_W      = 8;
	localparam int THR_W       = 11;
	localparam int ANGLE_CMD_W = 12;
	localparam int THR_CMD_W   = 15;

	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_LOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_HIGH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_TOP = 3'd4;

	localparam logic        [PULSE_W-1:0] PULSE_MIN_RST = 12'd1000;
	localparam logic        [PULSE_W-1:0] PULSE_MAX_RST = 12'd2000;
	localparam logic signed [TILT_W-1:0]  TILT_LOW_RST  = -8'sd30;
	localparam logic signed [TILT_W-1:0]  TILT_HIGH_RST = 8'sd30;
	localparam logic        [THR_W-1:0]   THR_TOP_RST   = 11'd2000;

	// Acceptance window on the measured width, open at both ends
	localparam int WIN_LOW  = 1000;
	localparam int WIN_HIGH = 2000;

	// Datapath widths
	localparam int WIDTH_W  = 11;  // widths inside the window stay below 2048
	localparam int DIFF_W   = 13;
	localparam int SPAN_W   = 12;
	localparam int LO_W     = 11;
	localparam int DEN_W    = 13;
	localparam int PROD1_W  = DIFF_W + SPAN_W;
	localparam int PROD2_W  = LO_W + DEN_W;
	localparam int SUM_W    = 24;
	localparam int NUM_W    = SUM_W + 4;
	localparam int MAG_W    = NUM_W - 1;

	localparam logic signed [LO_W-1:0] THROTTLE_BASE = 11'sd1000;

	localparam logic [CHAN_W-1:0] TGT_ROLL     = 2'd0;
	localparam logic [CHAN_W-1:0] TGT_PITCH    = 2'd1;
	localparam logic [CHAN_W-1:0] TGT_THROTTLE = 2'd2;

	typedef struct packed {
		logic capture;
		logic mul1;
		logic mul2;
		logic sum;
		logic div_step;
		logic commit;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic need_map;
	} dp_sts_t;

endpackage

`default_nettype wire

// ----- sv/rcpwd_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcpwd_ctrl
// Sequencer for the pulse-width decoder: input handshake, multiply and
// divide steps, result register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpwd_ctrl import rcpwd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL1   = 3'd1;
	localparam logic [2:0] ST_MUL2   = 3'd2;
	localparam logic [2:0] ST_SUM    = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_COMMIT = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	localparam int CNT_W = $clog2(MAG_W);

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept, out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = accept;
				if (accept) begin
					state_d = sts.need_map ? ST_MUL1 : ST_DONE;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.sum) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/rcpwd_dp.sv -----
// ----------------------------------------------------------------------------
// rcpwd_dp
// Datapath of the pulse-width decoder: configuration registers, per-channel
// edge tracking, linear map through two multiplies and a restoring divider,
// saturation, held commands and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpwd_dp import rcpwd_pkg::*; #(
	parameter int STAMP_BITS = STAMP_BITS_DEF,
	parameter int CHANNELS   = CHANNELS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data,
	input  wire logic [CHAN_W-1:0]             channel,
	input  wire logic [STAMP_W-1:0]            stamp,
	input  wire dp_cmd_t                       cmd,
	output dp_sts_t                            sts,
	output logic signed [ANGLE_CMD_W-1:0]      roll_cmd,
	output logic signed [ANGLE_CMD_W-1:0]      pitch_cmd,
	output logic        [THR_CMD_W-1:0]        throttle_cmd,
	output logic                               pulse_accepted
);

	// configuration
	logic        [PULSE_W-1:0] pulse_min_q, pulse_max_q;
	logic signed [TILT_W-1:0]  tilt_low_q, tilt_high_q;
	logic        [THR_W-1:0]   throttle_top_q;

	// edge tracking
	logic [CHANNELS-1:0]   awaiting_q;
	logic [STAMP_BITS-1:0] rise_q [CHANNELS];
	logic [CHANNELS-1:0]   hit;
	logic [STAMP_BITS-1:0] st, rise_sel, width_raw;
	logic [31:0]           width_ext;
	logic                  fall_sel, in_window, span_ok;

	// map
	logic [WIDTH_W-1:0]        w_q;
	logic [CHAN_W-1:0]         tgt_q;
	logic signed [LO_W-1:0]    lo_sel;
	logic signed [SPAN_W-1:0]  hi_sel, span;
	logic signed [DIFF_W-1:0]  diff;
	logic [PULSE_W-1:0]        d_span;
	logic signed [DEN_W-1:0]   den;
	logic signed [PROD1_W-1:0] prod1_q;
	logic signed [PROD2_W-1:0] prod2_q;
	logic signed [SUM_W-1:0]   sum;
	logic signed [NUM_W-1:0]   num, mag;
	logic [MAG_W-1:0]          quo_q;
	logic [PULSE_W-1:0]        rem_q;
	logic                      neg_q;
	logic [PULSE_W:0]          shifted, dvs, trial;
	logic                      ge;
	logic signed [NUM_W-1:0]   qmag, qval, lim_a, lim_b, lim_mn, lim_mx, qsat;

	// held commands
	logic signed [ANGLE_CMD_W-1:0] roll_hold_q, pitch_hold_q;
	logic        [THR_CMD_W-1:0]   throttle_hold_q;
	logic                          acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q    <= PULSE_MIN_RST;
			pulse_max_q    <= PULSE_MAX_RST;
			tilt_low_q     <= TILT_LOW_RST;
			tilt_high_q    <= TILT_HIGH_RST;
			throttle_top_q <= THR_TOP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PULSE_MIN:    pulse_min_q    <= cfg_data[PULSE_W-1:0];
				REG_PULSE_MAX:    pulse_max_q    <= cfg_data[PULSE_W-1:0];
				REG_TILT_LOW:     tilt_low_q     <= cfg_data[TILT_W-1:0];
				REG_TILT_HIGH:    tilt_high_q    <= cfg_data[TILT_W-1:0];
				REG_THROTTLE_TOP: throttle_top_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// select the addressed channel and measure the pulse
	always_comb begin
		st       = STAMP_BITS'(stamp);
		rise_sel = '0;
		fall_sel = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			hit[i] = (32'(channel) == 32'(i));
			if (hit[i]) begin
				rise_sel = rise_q[i];
				fall_sel = awaiting_q[i];
			end
		end
		width_raw    = st - rise_sel;
		width_ext    = 32'(width_raw);
		in_window    = (width_ext > 32'(WIN_LOW)) && (width_ext < 32'(WIN_HIGH));
		span_ok      = pulse_max_q > pulse_min_q;
		sts.need_map = fall_sel && in_window && span_ok && (channel <= TGT_THROTTLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= '0;
		end else if (cmd.capture) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (hit[i]) begin
					awaiting_q[i] <= !awaiting_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (hit[i] && !awaiting_q[i]) begin
					rise_q[i] <= st;
				end
			end
		end
	end

	// range end points and operands of the map
	always_comb begin
		if (tgt_q == TGT_THROTTLE) begin
			lo_sel = THROTTLE_BASE;
			hi_sel = signed'({1'b0, throttle_top_q});
		end else begin
			lo_sel = LO_W'(tilt_low_q);
			hi_sel = SPAN_W'(tilt_high_q);
		end
		span    = hi_sel - SPAN_W'(lo_sel);
		diff    = signed'({2'b00, w_q}) - signed'({1'b0, pulse_min_q});
		d_span  = pulse_max_q - pulse_min_q;
		den     = signed'({1'b0, d_span});
		sum     = SUM_W'(prod1_q) + prod2_q;
		num     = signed'({sum, 4'b0000});
		mag     = num[NUM_W-1] ? -num : num;
		shifted = {rem_q, quo_q[MAG_W-1]};
		dvs     = {1'b0, d_span};
		trial   = shifted - dvs;
		ge      = shifted >= dvs;
		qmag    = signed'({1'b0, quo_q});
		qval    = neg_q ? -qmag : qmag;
		lim_a   = NUM_W'(lo_sel) <<< 4;
		lim_b   = NUM_W'(hi_sel) <<< 4;
		lim_mn  = (lim_a < lim_b) ? lim_a : lim_b;
		lim_mx  = (lim_a < lim_b) ? lim_b : lim_a;
		if (qval < lim_mn) begin
			qsat = lim_mn;
		end else if (qval > lim_mx) begin
			qsat = lim_mx;
		end else begin
			qsat = qval;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			w_q   <= width_ext[WIDTH_W-1:0];
			tgt_q <= channel;
		end
		if (cmd.mul1) begin
			prod1_q <= PROD1_W'(diff) * PROD1_W'(span);
		end
		if (cmd.mul2) begin
			prod2_q <= PROD2_W'(lo_sel) * PROD2_W'(den);
		end
		if (cmd.sum) begin
			neg_q <= num[NUM_W-1];
			quo_q <= mag[MAG_W-1:0];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial[PULSE_W-1:0] : shifted[PULSE_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_hold_q     <= '0;
			pitch_hold_q    <= '0;
			throttle_hold_q <= '0;
			acc_q           <= 1'b0;
		end else if (cmd.capture) begin
			acc_q <= 1'b0;
		end else if (cmd.commit) begin
			acc_q <= 1'b1;
			case (tgt_q)
				TGT_ROLL:     roll_hold_q     <= qsat[ANGLE_CMD_W-1:0];
				TGT_PITCH:    pitch_hold_q    <= qsat[ANGLE_CMD_W-1:0];
				TGT_THROTTLE: throttle_hold_q <= qsat[THR_CMD_W-1:0];
				default: ;
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			roll_cmd       <= roll_hold_q;
			pitch_cmd      <= pitch_hold_q;
			throttle_cmd   <= throttle_hold_q;
			pulse_accepted <= acc_q;
		end
	end

endmodule

`default_nettype wire

// ----- sv/rc_pulse_width_decoder.sv -----
// A completed pulse inside the window, with pulse max above pulse min, is mapped
//   through two multiplies, a 27-step restoring divider and saturation.
// Other events skip the map and go straight to the result register.
// One event is in flight at a time: none is taken before the last one's word is loaded;
//   the next event is taken while the last word still waits at the output.
// Reset clears edge state and held commands and loads the register defaults.
// ----------------------------------------------------------------------------
// rc_pulse_width_decoder
// Three-channel RC receiver pulse-width decoder: measures pulse widths from
// edge stamps and maps them to held roll, pitch and throttle commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pulse_width_decoder import rcpwd_pkg::*; #(
	parameter int STAMP_BITS = STAMP_BITS_DEF,
	parameter int CHANNELS   = CHANNELS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [CHAN_W-1:0]        channel,
	input  wire logic [STAMP_W-1:0]       stamp,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [ANGLE_CMD_W-1:0] roll_cmd,
	output logic signed [ANGLE_CMD_W-1:0] pitch_cmd,
	output logic        [THR_CMD_W-1:0]   throttle_cmd,
	output logic                          pulse_accepted
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	rcpwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rcpwd_dp #(
		.STAMP_BITS (STAMP_BITS),
		.CHANNELS   (CHANNELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.channel        (channel),
		.stamp          (stamp),
		.cmd            (cmd),
		.sts            (sts),
		.roll_cmd       (roll_cmd),
		.pitch_cmd      (pitch_cmd),
		.throttle_cmd   (throttle_cmd),
		.pulse_accepted (pulse_accepted)
	);

endmodule

`default_nettype wire

// ----- sv/rcpwd_checker.sv -----
// ----------------------------------------------------------------------------
// rcpwd_checker
// Port-level checks for the pulse-width decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpwd_checker import rcpwd_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic signed [ANGLE_CMD_W-1:0] roll_cmd,
	input wire logic signed [ANGLE_CMD_W-1:0] pitch_cmd,
	input wire logic        [THR_CMD_W-1:0]   throttle_cmd,
	input wire logic                     pulse_accepted
);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(roll_cmd) && $stable(pitch_cmd)
			&& $stable(throttle_cmd) && $stable(pulse_accepted))
		else $error("result word changed while stalled");

	// one event in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again before the word was produced");

	// a new word appears as the block returns to idle
	a_word_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("word raised while still busy");

endmodule

bind rc_pulse_width_decoder rcpwd_checker u_checker (.*);

`default_nettype wire

// ----- dv/tb_rc_pulse_width_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rc_pulse_width_decoder
// Self-checking bench for the RC pulse-width decoder. Edge events are sent
// over the valid/ready input while a behavioral decoder in the bench tracks
// per-channel edge state, measures widths and maps them to held commands.
// Every returned word is compared field by field with the oldest prediction.
// Covers window edges, stamp wrap, spare channels, register extremes and
// masking, random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------

module tb_rc_pulse_width_decoder;
	import rcpwd_pkg::*;

	localparam logic [CHAN_W-1:0] CHAN_SPARE = 2'd3;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic signed [ANGLE_CMD_W-1:0] roll;
		logic signed [ANGLE_CMD_W-1:0] pitch;
		logic        [THR_CMD_W-1:0]   throttle;
		logic                          accepted;
	} cmd_word_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_DATA_W-1:0]         cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [CHAN_W-1:0]             channel = '0;
	logic [STAMP_W-1:0]            stamp = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [ANGLE_CMD_W-1:0] roll_cmd;
	logic signed [ANGLE_CMD_W-1:0] pitch_cmd;
	logic        [THR_CMD_W-1:0]   throttle_cmd;
	logic                          pulse_accepted;

	cmd_word_t held_cmd_q[$];
	int        error_count = 0;
	int        idle_cycles = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	logic      hold_rx = 1'b0;

	int                 map_pmin = int'(PULSE_MIN_RST);
	int                 map_pmax = int'(PULSE_MAX_RST);
	int                 tilt_lo  = int'(TILT_LOW_RST);
	int                 tilt_hi  = int'(TILT_HIGH_RST);
	int                 thr_top  = int'(THR_TOP_RST);
	logic               fall_pending[CHANNELS_DEF] = '{default: 1'b0};
	logic [STAMP_W-1:0] rise_at[CHANNELS_DEF] = '{default: '0};
	int                 roll_now = 0;
	int                 pitch_now = 0;
	int                 thr_now = 0;

	rc_pulse_width_decoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.channel        (channel),
		.stamp          (stamp),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.roll_cmd       (roll_cmd),
		.pitch_cmd      (pitch_cmd),
		.throttle_cmd   (throttle_cmd),
		.pulse_accepted (pulse_accepted)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int map_cmd(int w, int lo, int hi);
		longint d, n, q, a, b, mn, mx;
		d = longint'(map_pmax) - map_pmin;
		n = (longint'(w) - map_pmin) * (hi - lo) * 16 + longint'(lo) * 16 * d;
		q = n / d;
		a = longint'(lo) * 16;
		b = longint'(hi) * 16;
		mn = (a < b) ? a : b;
		mx = (a < b) ? b : a;
		if (q < mn) q = mn;
		if (q > mx) q = mx;
		return int'(q);
	endfunction

	function automatic cmd_word_t decode_event(logic [CHAN_W-1:0] ch, logic [STAMP_W-1:0] st);
		cmd_word_t r;
		logic [STAMP_W-1:0] w;
		r.accepted = 1'b0;
		if (int'(ch) < CHANNELS_DEF) begin
			if (!fall_pending[ch]) begin
				rise_at[ch] = st;
				fall_pending[ch] = 1'b1;
			end else begin
				w = st - rise_at[ch];
				fall_pending[ch] = 1'b0;
				if (int'(w) > WIN_LOW && int'(w) < WIN_HIGH && map_pmax > map_pmin) begin
					case (ch)
						TGT_ROLL: roll_now = map_cmd(int'(w), tilt_lo, tilt_hi);
						TGT_PITCH: pitch_now = map_cmd(int'(w), tilt_lo, tilt_hi);
						default: thr_now = map_cmd(int'(w), int'(THROTTLE_BASE), thr_top);
					endcase
					r.accepted = 1'b1;
				end
			end
		end
		r.roll = roll_now[ANGLE_CMD_W-1:0];
		r.pitch = pitch_now[ANGLE_CMD_W-1:0];
		r.throttle = thr_now[THR_CMD_W-1:0];
		return r;
	endfunction

	function automatic int pick_width();
		int dice;
		dice = $urandom_range(99);
		if (dice < 70) return $urandom_range(WIN_HIGH - 1, WIN_LOW + 1);
		if (dice < 78) return $urandom_range(WIN_LOW);
		if (dice < 86) return $urandom_range(WIN_HIGH + 300, WIN_HIGH);
		return $urandom_range(65535);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR: %s got %0d expected %0d at %0t", what, got, want, $time);
		error_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_PULSE_MIN: map_pmin = int'(data);
			REG_PULSE_MAX: map_pmax = int'(data);
			REG_TILT_LOW: tilt_lo = int'($signed(data[TILT_W-1:0]));
			REG_TILT_HIGH: tilt_hi = int'($signed(data[TILT_W-1:0]));
			REG_THROTTLE_TOP: thr_top = int'(data[THR_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic load_settings(input int pmin, input int pmax, input int tl, input int th,
			input int tt);
		write_reg(REG_PULSE_MIN, 12'(pmin));
		write_reg(REG_PULSE_MAX, 12'(pmax));
		write_reg(REG_TILT_LOW, {4'($urandom), 8'(tl)});
		write_reg(REG_TILT_HIGH, {4'($urandom), 8'(th)});
		write_reg(REG_THROTTLE_TOP, {1'($urandom), 11'(tt)});
		write_reg(REG_THROTTLE_TOP + CFG_IDX_W'($urandom_range(3, 1)), 12'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(input logic [CHAN_W-1:0] ch, input logic [STAMP_W-1:0] st);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		stamp <= st;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		held_cmd_q.push_back(decode_event(ch, st));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (held_cmd_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_traffic(input int count);
		int sent;
		logic [CHAN_W-1:0] ch_a, ch_b, ch_n;
		logic [STAMP_W-1:0] rise_a, rise_b;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 85) begin
				ch_a = CHAN_W'($urandom_range(2));
				rise_a = STAMP_W'($urandom);
				if ($urandom_range(99) < 25) begin
					ch_b = CHAN_W'((int'(ch_a) + 1 + int'($urandom_range(1))) % 3);
					rise_b = STAMP_W'($urandom);
					send_word(ch_a, rise_a);
					send_word(ch_b, rise_b);
					send_word(ch_a, 16'(rise_a + pick_width()));
					send_word(ch_b, 16'(rise_b + pick_width()));
					sent += 4;
				end else begin
					send_word(ch_a, rise_a);
					send_word(ch_a, 16'(rise_a + pick_width()));
					sent += 2;
				end
			end else begin
				ch_n = CHAN_W'($urandom_range(3));
				send_word(ch_n, STAMP_W'($urandom));
				if (ch_n != CHAN_SPARE) sent++;
			end
		end
	endtask

	task automatic apply_and_run(input int pmin, input int pmax, input int tl, input int th,
			input int tt, input int count);
		load_settings(pmin, pmax, tl, th, tt);
		run_traffic(count);
		drain();
	endtask

	task automatic test_directed_edges();
		send_word(TGT_ROLL, 16'd0);
		send_word(TGT_ROLL, 16'd1001);
		send_word(TGT_PITCH, 16'hFFFF);
		send_word(TGT_PITCH, 16'd1998);
		send_word(TGT_THROTTLE, 16'd5000);
		send_word(TGT_THROTTLE, 16'd6500);
		send_word(TGT_ROLL, 16'd100);
		send_word(TGT_ROLL, 16'd1100);
		send_word(TGT_PITCH, 16'd200);
		send_word(TGT_PITCH, 16'd2200);
		send_word(CHAN_SPARE, 16'hFFFF);
		send_word(CHAN_SPARE, 16'h0000);
		send_word(TGT_THROTTLE, 16'h8000);
		send_word(TGT_THROTTLE, 16'h8000);
		send_word(TGT_ROLL, 16'd1);
		send_word(TGT_ROLL, 16'd0);
		send_word(TGT_THROTTLE, 16'd10);
		send_word(CHAN_SPARE, 16'd20);
		send_word(TGT_THROTTLE, 16'd1910);
		send_word(TGT_ROLL, 16'hAAAA);
		send_word(TGT_PITCH, 16'h5555);
		send_word(TGT_ROLL, 16'd45190);
		send_word(TGT_PITCH, 16'd23345);
		drain();
	endtask

	task automatic test_register_sweep();
		apply_and_run(0, 4095, -90, 90, 2000, 40);
		apply_and_run(1200, 1800, 90, -90, 1000, 40);
		apply_and_run(1500, 1500, -30, 30, 2000, 30);
		apply_and_run(1800, 1200, 10, 20, 1500, 30);
		apply_and_run(4095, 0, -90, 90, 1000, 30);
		apply_and_run(1001, 1999, -90, -90, 1999, 40);
	endtask

	task automatic test_idle_phases();
		int send_pct[4];
		int recv_pct[4];
		send_pct = '{0, 83, 0, 30};
		recv_pct = '{0, 0, 83, 30};
		for (int i = 0; i < 4; i++) begin
			send_idle_pct = send_pct[i];
			recv_stall_pct = recv_pct[i];
			apply_and_run($urandom_range(1400, 800), $urandom_range(2200, 1600),
				$urandom_range(180) - 90, $urandom_range(180) - 90,
				$urandom_range(2000, 1000), 300);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_output_backpressure();
		load_settings(int'(PULSE_MIN_RST), int'(PULSE_MAX_RST), int'(TILT_LOW_RST),
			int'(TILT_HIGH_RST), int'(THR_TOP_RST));
		fork
			begin
				hold_rx <= 1'b1;
				repeat (400) @(posedge clk);
				hold_rx <= 1'b0;
			end
			run_traffic(100);
		join
		drain();
	endtask

	initial begin
		cmd_word_t want;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (held_cmd_q.size() == 0) begin
					report_mismatch("unexpected word, roll_cmd", int'(roll_cmd), 0);
				end else begin
					want = held_cmd_q.pop_front();
					if (roll_cmd !== want.roll)
						report_mismatch("roll_cmd", int'(roll_cmd), int'(want.roll));
					if (pitch_cmd !== want.pitch)
						report_mismatch("pitch_cmd", int'(pitch_cmd), int'(want.pitch));
					if (throttle_cmd !== want.throttle)
						report_mismatch("throttle_cmd", int'(throttle_cmd),
							int'(want.throttle));
					if (pulse_accepted !== want.accepted)
						report_mismatch("pulse_accepted", int'(pulse_accepted),
							int'(want.accepted));
				end
			end
			out_ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_register_sweep();
		test_idle_phases();
		test_output_backpressure();
		if (held_cmd_q.size() != 0)
			report_mismatch("words never delivered", held_cmd_q.size(), 0);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/rcpwd_pkg.sv
sv/rcpwd_ctrl.sv
sv/rcpwd_dp.sv
sv/rc_pulse_width_decoder.sv
sv/rcpwd_checker.sv
dv/tb_rc_pulse_width_decoder.sv
